// File: design/aad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_pkg
// Shared types and constants of the area-average downscaler.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int MAX_OUT_WIDTH = 2048;
  localparam int SUM_BITS      = 40;
  localparam int COL_BITS      = $clog2(MAX_OUT_WIDTH);
  localparam int FILL_BITS     = COL_BITS + 1;
  localparam int ADDR_BITS     = COL_BITS + 1;
  localparam int CFG_IDX_BITS  = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_BITS      = ((SUM_BITS > 40) ? SUM_BITS : 40) + 1;
  localparam int PROD_BITS     = 36;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_WIDTH   = 8'd0,
    REG_IN_HEIGHT  = 8'd1,
    REG_OUT_WIDTH  = 8'd2,
    REG_OUT_HEIGHT = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } src_pix_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       end_of_line;
    logic       end_of_frame;
  } dst_pix_t;

  // effective (clamped) frame geometry
  typedef struct packed {
    logic [15:0] iw;
    logic [15:0] ih;
    logic [11:0] ow;
    logic [15:0] oh;
  } geom_t;

  // one classified source pixel, front to back
  typedef struct packed {
    src_pix_t    pix;
    logic [11:0] xa;
    logic [11:0] xb;
    logic [15:0] ya;
    logic [15:0] yb;
    logic [11:0] tc;
    logic        emit;
    logic        eol;
    logic        eof;
    logic        swap;
    logic        wipe;
  } cmd_t;

  typedef logic [SUM_BITS-1:0] sum_t;
  typedef sum_t [2:0] sums_t;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_RD,
    BE_MUL,
    BE_WR,
    BE_ORD,
    BE_ODAT,
    BE_DIV,
    BE_OUT,
    BE_FIN
  } be_state_t;

  typedef struct packed {
    logic pop;
    logic rd_upd;
    logic wr;
    logic rd_out;
    logic div_load;
    logic div_step;
    logic out_load;
    logic swap;
  } be_ctrl_t;

endpackage

// File: design/aad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_front
// Phase counters: splits each source pixel's weight over target columns/rows.
// ----------------------------------------------------------------------------
module aad_front import aad_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     restart,
  input  geom_t    geom,
  input  logic     accept,
  input  src_pix_t pix,
  output cmd_t     cmd
);

  logic [15:0] column_phase, row_phase, source_column, target_row;
  logic [11:0] target_column;
  logic [16:0] s, t;
  logic        cclose, rclose, line_end, frame_last;
  logic [15:0] np, nr;

  always_comb begin
    s = {1'b0, column_phase} + {5'b0, geom.ow};
    t = {1'b0, row_phase} + {1'b0, geom.oh};
    cmd.pix = pix;
    cmd.tc  = target_column;
    if (s > {1'b0, geom.iw}) begin
      cmd.xa = 12'(geom.iw - column_phase);
      cmd.xb = 12'(s - {1'b0, geom.iw});
      cclose = 1'b1;
      np     = 16'(cmd.xb);
    end else begin
      cmd.xa = geom.ow;
      cmd.xb = '0;
      cclose = (s == {1'b0, geom.iw});
      np     = cclose ? 16'd0 : s[15:0];
    end
    if (t > {1'b0, geom.ih}) begin
      cmd.ya = geom.ih - row_phase;
      cmd.yb = 16'(t - {1'b0, geom.ih});
      rclose = 1'b1;
      nr     = cmd.yb;
    end else begin
      cmd.ya = geom.oh;
      cmd.yb = '0;
      rclose = (t == {1'b0, geom.ih});
      nr     = rclose ? 16'd0 : t[15:0];
    end
    line_end   = ({1'b0, source_column} + 17'd1) >= {1'b0, geom.iw};
    frame_last = ({1'b0, target_row} + 17'd1) >= {1'b0, geom.oh};
    cmd.emit = rclose && cclose;
    cmd.eol  = line_end;
    cmd.eof  = line_end && frame_last;
    cmd.swap = line_end && rclose;
    cmd.wipe = line_end && rclose && frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_phase  <= '0;
      row_phase     <= '0;
      source_column <= '0;
      target_column <= '0;
      target_row    <= '0;
    end else if (accept) begin
      if (line_end) begin
        column_phase  <= '0;
        source_column <= '0;
        target_column <= '0;
        row_phase     <= nr;
        if (rclose) begin
          if (frame_last) begin
            target_row <= '0;
            row_phase  <= '0;
          end else begin
            target_row <= target_row + 16'd1;
          end
        end
      end else begin
        column_phase  <= np;
        source_column <= source_column + 16'd1;
        if (cclose) begin
          target_column <= target_column + 12'd1;
        end
      end
    end
  end

endmodule

// File: design/aad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module aad_queue import aad_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rdata
);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp, rp;
  logic [QCNT_BITS-1:0] cnt;

  assign full  = (cnt == QCNT_BITS'(QUEUE_DEPTH));
  assign valid = (cnt != '0);
  assign rdata = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

endmodule

// File: design/aad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_back
// Line-store accumulation, output divide and line exchange, one command a time.
// ----------------------------------------------------------------------------
module aad_back import aad_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     restart,
  input  geom_t    geom,
  input  logic     q_valid,
  input  cmd_t     q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output dst_pix_t out_pix
);

  be_state_t state, state_next;
  be_ctrl_t  ctrl;

  cmd_t                 cmd;
  logic [1:0]           k;
  logic [2:0]           bit_idx;
  logic                 sel;
  logic [FILL_BITS-1:0] fill [2];
  logic [31:0]          den;

  // line store: both banks in one memory, bank in the top address bit
  sums_t                mem [2 * MAX_OUT_WIDTH];
  sums_t                rdata;
  logic                 rlive;
  logic [ADDR_BITS-1:0] raddr, waddr;

  logic [11:0]          x;
  logic [15:0]          y;
  logic [12:0]          col, ocol_ext;
  logic                 col_ok, skip, bank_k;
  logic [COL_BITS-1:0]  ocol;

  logic [27:0]          w;
  logic [PROD_BITS-1:0] prod [3];
  sums_t                wdata;
  logic [SUM_BITS:0]    tsum;

  logic [DIV_BITS-1:0]  rem [3];
  logic [7:0]           quo [3];
  logic [2:0]           sat;
  logic [DIV_BITS-1:0]  dsh;
  logic [DIV_BITS-1:0]  dmax;
  logic [7:0]           chan [3];

  assign x        = k[0] ? cmd.xb : cmd.xa;
  assign y        = k[1] ? cmd.yb : cmd.ya;
  assign col      = {1'b0, cmd.tc} + {12'b0, k[0]};
  assign col_ok   = 32'(col) < 32'(MAX_OUT_WIDTH);
  assign skip     = (x == '0) || (y == '0) || !col_ok;
  assign bank_k   = sel ^ k[1];
  assign ocol_ext = (32'(cmd.tc) < 32'(MAX_OUT_WIDTH)) ? {1'b0, cmd.tc}
                                                       : 13'(MAX_OUT_WIDTH - 1);
  assign ocol     = ocol_ext[COL_BITS-1:0];
  assign waddr    = {bank_k, col[COL_BITS-1:0]};
  assign raddr    = ctrl.rd_out ? {sel, ocol} : waddr;
  assign q_pop    = ctrl.pop;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BE_IDLE: if (q_valid) state_next = BE_RD;
      BE_RD: begin
        if (!skip) state_next = BE_MUL;
        else if (k == 2'd3) state_next = cmd.emit ? BE_ORD : BE_FIN;
      end
      BE_MUL: state_next = BE_WR;
      BE_WR: begin
        if (k == 2'd3) state_next = cmd.emit ? BE_ORD : BE_FIN;
        else state_next = BE_RD;
      end
      BE_ORD:  state_next = BE_ODAT;
      BE_ODAT: state_next = BE_DIV;
      BE_DIV:  if (bit_idx == '0) state_next = BE_OUT;
      BE_OUT:  if (!out_valid || !out_stall) state_next = BE_FIN;
      BE_FIN:  state_next = BE_IDLE;
      default: state_next = BE_IDLE;
    endcase
  end

  // controls
  always_comb begin
    ctrl          = '0;
    ctrl.pop      = (state == BE_IDLE) && q_valid;
    ctrl.rd_upd   = (state == BE_RD) && !skip;
    ctrl.wr       = (state == BE_WR);
    ctrl.rd_out   = (state == BE_ORD);
    ctrl.div_load = (state == BE_ODAT);
    ctrl.div_step = (state == BE_DIV);
    ctrl.out_load = (state == BE_OUT) && (!out_valid || !out_stall);
    ctrl.swap     = (state == BE_FIN) && cmd.swap;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // saturating accumulate
  always_comb begin
    tsum = '0;
    for (int c = 0; c < 3; c++) begin
      tsum = {1'b0, (rlive ? rdata[c] : sum_t'(0))} + (SUM_BITS + 1)'(prod[c]);
      wdata[c] = tsum[SUM_BITS] ? {SUM_BITS{1'b1}} : tsum[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd_upd || ctrl.rd_out) begin
      rdata <= mem[raddr];
      rlive <= (FILL_BITS + 1)'(raddr[COL_BITS-1:0]) <
               (FILL_BITS + 1)'(fill[raddr[ADDR_BITS-1]]);
    end
  end

  // fill counts stand in for clearing: entries at or above the count read as 0
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sel     <= 1'b0;
      fill[0] <= '0;
      fill[1] <= '0;
    end else if (ctrl.wr) begin
      if ((FILL_BITS + 1)'(col) >= (FILL_BITS + 1)'(fill[bank_k])) begin
        fill[bank_k] <= FILL_BITS'(col + 13'd1);
      end
    end else if (ctrl.swap) begin
      sel       <= ~sel;
      fill[sel] <= '0;
      if (cmd.wipe) begin
        fill[~sel] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      k <= '0;
    end else if (ctrl.pop) begin
      k <= '0;
    end else if (((state == BE_RD) && skip) || ctrl.wr) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    den <= 32'(geom.iw) * 32'(geom.ih);
    if (ctrl.pop) begin
      cmd <= q_data;
    end
    if (ctrl.rd_upd) begin
      w <= 28'(x) * 28'(y);
    end
    if (state == BE_MUL) begin
      prod[0] <= PROD_BITS'(w) * PROD_BITS'(cmd.pix.blue);
      prod[1] <= PROD_BITS'(w) * PROD_BITS'(cmd.pix.green);
      prod[2] <= PROD_BITS'(w) * PROD_BITS'(cmd.pix.red);
    end
  end

  // restoring divide, eight quotient bits, saturation checked up front
  assign dsh  = DIV_BITS'(den) << bit_idx;
  assign dmax = DIV_BITS'(den) << 8;

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      bit_idx <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        rem[c] <= DIV_BITS'(rlive ? rdata[c] : sum_t'(0));
        quo[c] <= '0;
        sat[c] <= DIV_BITS'(rlive ? rdata[c] : sum_t'(0)) >= dmax;
      end
    end else if (ctrl.div_step) begin
      bit_idx <= bit_idx - 3'd1;
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsh) begin
          rem[c]          <= rem[c] - dsh;
          quo[c][bit_idx] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c] = sat[c] ? 8'hFF : quo[c];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_pix.out_blue     <= chan[0];
      out_pix.out_green    <= chan[1];
      out_pix.out_red      <= chan[2];
      out_pix.end_of_line  <= cmd.eol;
      out_pix.end_of_frame <= cmd.eof;
    end
  end

endmodule

// File: design/area_average_downscaler.sv
`timescale 1ns / 1ps
// Timing: each accepted pixel takes the back end's read-multiply-write passes
//   (up to four), and one that closes a target pixel also the 8-step divider;
//   the queue takes further pixels meanwhile until it is full, and a result
//   waits in the back end while the output is stalled.
// Reset: synchronous; sizes return to 1, counters and line-store fill counts
//   clear at once, so there is no clearing pass.
// ----------------------------------------------------------------------------
// area_average_downscaler
// Area-averaging image downscaler, 24-bit raster pixels in, target pixels out.
// ----------------------------------------------------------------------------
module area_average_downscaler import aad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    src_valid,
  output logic                    src_stall,
  input  src_pix_t                src_pix,
  output logic                    dst_valid,
  input  logic                    dst_stall,
  output dst_pix_t                dst_pix,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data
);

  // configuration registers
  logic [15:0] in_width, in_height, out_height;
  logic [11:0] out_width;
  logic        cfg_hit, restart;
  geom_t       geom;
  logic [15:0] iw_e, ih_e;
  logic [11:0] ow_e;
  logic [15:0] oh_e;

  // front/back transactions
  cmd_t cmd_in, cmd_out;
  logic q_full, q_valid, q_pop, accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_IN_WIDTH, REG_IN_HEIGHT, REG_OUT_WIDTH, REG_OUT_HEIGHT: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // any write into the register list restarts the frame
  assign restart = cfg_valid && cfg_ready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= 16'd1;
      in_height  <= 16'd1;
      out_width  <= 12'd1;
      out_height <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_OUT_WIDTH:  out_width  <= cfg_data[11:0];
        REG_OUT_HEIGHT: out_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one; the target width is capped at 2048, and enlargement clamps the target to the source size
  always_comb begin
    iw_e = (in_width == '0) ? 16'd1 : in_width;
    ih_e = (in_height == '0) ? 16'd1 : in_height;
    ow_e = (out_width == '0) ? 12'd1 : out_width;
    if (32'(ow_e) > 32'(MAX_OUT_WIDTH)) ow_e = 12'(MAX_OUT_WIDTH);
    if ({4'b0, ow_e} > iw_e) ow_e = iw_e[11:0];
    oh_e = (out_height == '0) ? 16'd1 : out_height;
    if (oh_e > ih_e) oh_e = ih_e;
    geom.iw = iw_e;
    geom.ih = ih_e;
    geom.ow = ow_e;
    geom.oh = oh_e;
  end

  assign src_stall = q_full;
  assign accept    = src_valid && !src_stall;

  aad_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .geom    (geom),
    .accept  (accept),
    .pix     (src_pix),
    .cmd     (cmd_in)
  );

  aad_queue u_queue (
    .clk   (clk),
    .rst   (rst || restart),
    .push  (accept),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (cmd_out)
  );

  aad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .geom      (geom),
    .q_valid   (q_valid),
    .q_data    (cmd_out),
    .q_pop     (q_pop),
    .out_valid (dst_valid),
    .out_stall (dst_stall),
    .out_pix   (dst_pix)
  );

endmodule

// File: design/aad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_checker
// Port-level checks of the downscaler's result channel.
// ----------------------------------------------------------------------------
module aad_checker import aad_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     dst_valid,
  input logic     dst_stall,
  input dst_pix_t dst_pix
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> $stable(dst_pix))
    else $error("stalled result changed");

  a_eof_eol: assert property (@(posedge clk)
    dst_valid |-> (!dst_pix.end_of_frame || dst_pix.end_of_line))
    else $error("end of frame without end of line");

  a_reset: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid after reset");

endmodule

bind area_average_downscaler aad_checker u_aad_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_pix   (dst_pix)
);
